>>> design/assert_macros.svh
// Assertion shorthands for the table checker.
// Clock clk and active-low reset arst_n must be visible where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("table checker: same-cycle rule violated");

// Next-cycle implication.
`define CHK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("table checker: next-cycle rule violated");

`endif

>>> design/lkv_pkg.sv
package lkv_pkg;

	// Table geometry
	localparam int CAPACITY = 64;
	localparam int KEY_W    = 16;
	localparam int VAL_W    = 32;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Fixed port field widths
	localparam int OP_FW  = 2;
	localparam int KEY_FW = 16;
	localparam int VAL_FW = 32;
	localparam int ST_FW  = 2;
	localparam int POS_FW = 6;
	localparam int CNT_FW = 7;

	typedef enum logic [OP_FW-1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2
	} op_t;

	typedef enum logic [ST_FW-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} st_t;

	// Broadcast to every cell
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic             del_en;
		logic             ins_en;
	} lkv_bcast_t;

	// Per-cell control
	typedef struct packed {
		logic valid;
		logic append;
	} lkv_cell_ctl_t;

	function automatic logic [KEY_W-1:0] key_trim(input logic [KEY_FW-1:0] k);
		logic [KEY_W+KEY_FW-1:0] e;
		e = {{KEY_W{1'b0}}, k};
		return e[KEY_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] val_trim(input logic [VAL_FW-1:0] v);
		logic [VAL_W+VAL_FW-1:0] e;
		e = {{VAL_W{1'b0}}, v};
		return e[VAL_W-1:0];
	endfunction

	function automatic logic [VAL_FW-1:0] val_field(input logic [VAL_W-1:0] v);
		logic [VAL_W+VAL_FW-1:0] e;
		e = {{VAL_FW{1'b0}}, v};
		return e[VAL_FW-1:0];
	endfunction

	function automatic logic [POS_FW-1:0] pos_field(input logic [SLOT_W-1:0] s);
		logic [SLOT_W+POS_FW-1:0] e;
		e = {{POS_FW{1'b0}}, s};
		return e[POS_FW-1:0];
	endfunction

	function automatic logic [CNT_FW-1:0] cnt_field(input logic [CNT_W-1:0] c);
		logic [CNT_W+CNT_FW-1:0] e;
		e = {{CNT_FW{1'b0}}, c};
		return e[CNT_FW-1:0];
	endfunction

endpackage

>>> design/lkv_cell.sv
module lkv_cell (
	input  logic                       clk,
	input  lkv_pkg::lkv_bcast_t        bc,
	input  lkv_pkg::lkv_cell_ctl_t     ctl,
	input  logic                       hit_in,
	output logic                       hit_out,
	output logic                       first,
	input  logic [lkv_pkg::KEY_W-1:0]  nxt_key,
	input  logic [lkv_pkg::VAL_W-1:0]  nxt_val,
	output logic [lkv_pkg::KEY_W-1:0]  key_out,
	output logic [lkv_pkg::VAL_W-1:0]  val_out
);
	import lkv_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic             match;

	assign match   = ctl.valid && (key_q == bc.key);
	assign hit_out = hit_in || match;
	assign first   = match && !hit_in;
	assign key_out = key_q;
	assign val_out = val_q;

	// append at the tail, or pull from the right neighbor at and after the deleted slot
	always_ff @(posedge clk) begin
		if (bc.ins_en && ctl.append) begin
			key_q <= bc.key;
			val_q <= bc.value;
		end else if (bc.del_en && hit_out) begin
			key_q <= nxt_key;
			val_q <= nxt_val;
		end
	end

endmodule

>>> design/linear_key_value_table.sv
// Channel  Handshake              Word
// -------  ---------------------  -----------------------------------------------
// request  req_valid/req_ready    operation, key, item_value
// response rsp_valid/rsp_ready    status, position, found_value, fill_count
//
// A word is captured in the request stage; then every cell compares its key,
// the first-hit chain ripples down the row and the cells shift or append.
// The request stage holds one word at a time; a request is taken while a
// response still waits. arst_n clears the fill count and all valid flags;
// slots are don't-care until written. A stalled response holds the request stage.
module linear_key_value_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [lkv_pkg::OP_FW-1:0]   operation,
	input  logic [lkv_pkg::KEY_FW-1:0]  key,
	input  logic [lkv_pkg::VAL_FW-1:0]  item_value,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic [lkv_pkg::ST_FW-1:0]   status,
	output logic [lkv_pkg::POS_FW-1:0]  position,
	output logic [lkv_pkg::VAL_FW-1:0]  found_value,
	output logic [lkv_pkg::CNT_FW-1:0]  fill_count
);
	import lkv_pkg::*;

	// request stage
	logic              valid_s1;
	logic [OP_FW-1:0]  op_s1;
	logic [KEY_W-1:0]  key_s1;
	logic [VAL_W-1:0]  val_s1;

	// table occupancy
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_n;
	logic              full;

	// response register
	logic              rsp_valid_q;
	logic [ST_FW-1:0]  status_q;
	logic [POS_FW-1:0] position_q;
	logic [VAL_FW-1:0] found_value_q;
	logic [CNT_FW-1:0] fill_count_q;

	logic              accept;
	logic              advance;

	// cell row
	lkv_bcast_t        bc;
	lkv_cell_ctl_t     ctl [CAPACITY];
	logic [CAPACITY:0] hit_chain;
	logic [CAPACITY-1:0] first_vec;
	logic [KEY_W-1:0]  key_chain [CAPACITY+1];
	logic [VAL_W-1:0]  val_chain [CAPACITY+1];

	// gathered result
	logic              hit_any;
	logic [SLOT_W-1:0] hit_slot;
	logic [VAL_W-1:0]  hit_val;
	st_t               st_n;
	logic [POS_FW-1:0] pos_n;
	logic [VAL_FW-1:0] fv_n;

	assign req_ready = !valid_s1;
	assign accept    = req_valid && req_ready;
	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign full      = (count_q == CNT_W'(CAPACITY));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= operation;
			key_s1 <= key_trim(key);
			val_s1 <= val_trim(item_value);
		end
	end

	// broadcast; only one of the two write enables can be high
	always_comb begin
		bc.key    = key_s1;
		bc.value  = val_s1;
		bc.del_en = advance && (op_s1 == OP_DELETE);
		bc.ins_en = advance && (op_s1 == OP_INSERT) && !full;
	end

	assign hit_chain[0]        = 1'b0;
	assign key_chain[CAPACITY] = '0;
	assign val_chain[CAPACITY] = '0;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		// slots below the fill count are live; the slot at the count is the tail
		assign ctl[g].valid  = (CNT_W'(g) < count_q);
		assign ctl[g].append = (CNT_W'(g) == count_q);

		lkv_cell u_cell (
			.clk     (clk),
			.bc      (bc),
			.ctl     (ctl[g]),
			.hit_in  (hit_chain[g]),
			.hit_out (hit_chain[g+1]),
			.first   (first_vec[g]),
			.nxt_key (key_chain[g+1]),
			.nxt_val (val_chain[g+1]),
			.key_out (key_chain[g]),
			.val_out (val_chain[g])
		);
	end

	assign hit_any = hit_chain[CAPACITY];

	// first_vec is one-hot or zero, so an OR gather picks the first hit
	always_comb begin
		hit_slot = '0;
		hit_val  = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (first_vec[i]) begin
				hit_slot = hit_slot | SLOT_W'(i);
				hit_val  = hit_val | val_chain[i];
			end
		end
	end

	always_comb begin
		st_n    = ST_OK;
		pos_n   = '0;
		fv_n    = '0;
		count_n = count_q;
		case (op_s1)
			OP_LOOKUP: begin
				if (hit_any) begin
					pos_n = pos_field(hit_slot);
					fv_n  = val_field(hit_val);
				end else begin
					st_n = ST_MISS;
				end
			end
			OP_INSERT: begin
				if (full) begin
					st_n = ST_FULL;
				end else begin
					count_n = count_q + CNT_W'(1);
				end
			end
			OP_DELETE: begin
				if (hit_any) begin
					pos_n   = pos_field(hit_slot);
					count_n = count_q - CNT_W'(1);
				end else begin
					st_n = ST_MISS;
				end
			end
			default: begin
				st_n = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				count_q     <= count_n;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q      <= st_n;
			position_q    <= pos_n;
			found_value_q <= fv_n;
			fill_count_q  <= cnt_field(count_n);
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign position    = position_q;
	assign found_value = found_value_q;
	assign fill_count  = fill_count_q;

endmodule

>>> design/lkv_checker.sv
`include "assert_macros.svh"

module lkv_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic [lkv_pkg::OP_FW-1:0]   operation,
	input logic [lkv_pkg::KEY_FW-1:0]  key,
	input logic [lkv_pkg::VAL_FW-1:0]  item_value,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [lkv_pkg::ST_FW-1:0]   status,
	input logic [lkv_pkg::POS_FW-1:0]  position,
	input logic [lkv_pkg::VAL_FW-1:0]  found_value,
	input logic [lkv_pkg::CNT_FW-1:0]  fill_count
);
	import lkv_pkg::*;

	localparam logic [CNT_FW-1:0] FULL_CNT = cnt_field(CNT_W'(CAPACITY));

	// a request word waiting for ready holds
	`CHK_NEXT(a_req_hold, req_valid && !req_ready,
		req_valid && $stable(operation) && $stable(key) && $stable(item_value))

	// a stalled response word holds
	`CHK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
		rsp_valid && $stable(status) && $stable(position) && $stable(found_value) && $stable(fill_count))

	// a miss reports no slot and no data
	`CHK_NOW(a_miss_zero, rsp_valid && (status == ST_MISS), (position == '0) && (found_value == '0))

	// a dropped insert only happens at capacity and reports no slot and no data
	`CHK_NOW(a_full_cnt, rsp_valid && (status == ST_FULL),
		(fill_count == FULL_CNT) && (position == '0) && (found_value == '0))

	// data only comes back with an ok status
	`CHK_NOW(a_data_ok, rsp_valid && (found_value != '0), status == ST_OK)

endmodule

bind linear_key_value_table lkv_checker u_lkv_checker (.*);

>>> bench/testbench.sv
module testbench;
	import lkv_pkg::*;

	localparam int RANDOM_ITEMS   = 1900;
	localparam int WATCHDOG_LIMIT = 5000; // cycles with no handshake on either side
	localparam int TAIL_CYCLES    = 20;   // quiet time after the last response
	localparam int POOL_SIZE      = 24;

	// One request word plus a flag that holds it back until no response is outstanding
	typedef struct {
		op_t                op;
		logic [KEY_FW-1:0]  key;
		logic [VAL_FW-1:0]  value;
		bit                 wait_idle;
	} request_t;

	typedef struct {
		st_t                status;
		logic [POS_FW-1:0]  position;
		logic [VAL_FW-1:0]  found_value;
		logic [CNT_FW-1:0]  fill_count;
	} response_t;

	// Operation mix of a random segment
	typedef enum int {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} mix_t;

	// Receiver stall modes
	typedef enum int {
		READY_ALWAYS,
		READY_RANDOM,
		READY_SPARSE
	} stall_mode_t;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                req_valid   = 1'b0;
	logic                req_ready;
	logic [OP_FW-1:0]    operation   = '0;
	logic [KEY_FW-1:0]   key         = '0;
	logic [VAL_FW-1:0]   item_value  = '0;
	logic                rsp_valid;
	logic                rsp_ready   = 1'b0;
	logic [ST_FW-1:0]    status;
	logic [POS_FW-1:0]   position;
	logic [VAL_FW-1:0]   found_value;
	logic [CNT_FW-1:0]   fill_count;

	linear_key_value_table uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.operation   (operation),
		.key         (key),
		.item_value  (item_value),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.status      (status),
		.position    (position),
		.found_value (found_value),
		.fill_count  (fill_count)
	);

	always #5 clk = ~clk;

	// Shadow copy of the table, updated in acceptance order
	logic [KEY_W-1:0] shadow_keys [CAPACITY];
	logic [VAL_W-1:0] shadow_values [CAPACITY];
	int               shadow_count = 0;

	request_t  pending_requests [$];   // words not yet offered
	response_t expected_responses [$]; // predicted responses, oldest first
	request_t  in_flight;              // word currently on the request port

	logic [KEY_FW-1:0] key_pool [POOL_SIZE];

	int errors = 0;
	int quiet_cycles = 0;
	int gap_left = 0;
	int burst_left = 0;
	int random_items = 0;
	int n_lookup = 0, n_insert = 0, n_delete = 0;
	int n_hit = 0, n_miss = 0, n_full = 0, n_rsp = 0, peak_fill = 0;

	logic [15:0] stall_pattern = 16'hFFFF;
	int          mode_timer = 0;

	// Applies one request to the shadow table and returns the response it owes.
	// Search is first-match from slot 0; delete closes the gap by shifting down.
	function automatic response_t table_outcome(request_t r);
		response_t res;
		bit        hit;
		int        slot;
		res.status      = ST_OK;
		res.position    = '0;
		res.found_value = '0;
		hit  = 1'b0;
		slot = 0;
		if (r.op == OP_LOOKUP || r.op == OP_DELETE) begin
			for (int i = 0; i < shadow_count; i++) begin
				if (!hit && shadow_keys[i] == r.key[KEY_W-1:0]) begin
					hit  = 1'b1;
					slot = i;
				end
			end
		end
		case (r.op)
			OP_LOOKUP: begin
				if (hit) begin
					res.position    = POS_FW'(slot);
					res.found_value = VAL_FW'(shadow_values[slot]);
				end else begin
					res.status = ST_MISS;
				end
			end
			OP_INSERT: begin
				if (shadow_count >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					shadow_keys[shadow_count]   = r.key[KEY_W-1:0];
					shadow_values[shadow_count] = r.value[VAL_W-1:0];
					shadow_count++;
				end
			end
			OP_DELETE: begin
				if (hit) begin
					res.position = POS_FW'(slot);
					for (int j = slot; j + 1 < shadow_count; j++) begin
						shadow_keys[j]   = shadow_keys[j + 1];
						shadow_values[j] = shadow_values[j + 1];
					end
					shadow_count--;
				end else begin
					res.status = ST_MISS;
				end
			end
			default: ;
		endcase
		res.fill_count = CNT_FW'(shadow_count);
		return res;
	endfunction

	task automatic queue_request(op_t op, logic [KEY_FW-1:0] k, logic [VAL_FW-1:0] v,
		bit wait_idle);
		request_t r;
		r.op        = op;
		r.key       = k;
		r.value     = v;
		r.wait_idle = wait_idle;
		pending_requests.push_back(r);
	endtask

	// Mostly keys from a small pool so lookups and deletes hit; some fully random.
	function automatic logic [KEY_FW-1:0] pick_key();
		if ($urandom_range(0, 99) < 85)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		return KEY_FW'($urandom_range(0, 65535));
	endfunction

	function automatic logic [VAL_FW-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic op_t pick_op(mix_t mix);
		int roll;
		roll = $urandom_range(0, 99);
		case (mix)
			MIX_FILL:  return roll < 80 ? OP_INSERT : (roll < 90 ? OP_LOOKUP : OP_DELETE);
			MIX_DRAIN: return roll < 65 ? OP_DELETE : (roll < 90 ? OP_LOOKUP : OP_INSERT);
			default:   return roll < 34 ? OP_INSERT : (roll < 67 ? OP_LOOKUP : OP_DELETE);
		endcase
	endfunction

	// Request driver: bursts of random length separated by random gaps.
	// Accepted words go through the shadow table right away.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid  <= 1'b0;
			operation  <= '0;
			key        <= '0;
			item_value <= '0;
			gap_left   = 0;
			burst_left = 0;
		end else begin
			if (req_valid && req_ready) begin
				expected_responses.push_back(table_outcome(in_flight));
				case (in_flight.op)
					OP_LOOKUP: n_lookup++;
					OP_INSERT: n_insert++;
					OP_DELETE: n_delete++;
					default: ;
				endcase
				case (expected_responses[$].status)
					ST_MISS: n_miss++;
					ST_FULL: n_full++;
					default: if (in_flight.op != OP_INSERT) n_hit++;
				endcase
				if (shadow_count > peak_fill)
					peak_fill = shadow_count;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					// occasional long gap, otherwise short or none
					gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20)
						: $urandom_range(0, 2);
					burst_left = $urandom_range(1, 40);
				end
			end
			// port free: either nothing offered or the offered word just went in
			if (!req_valid || req_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (pending_requests.size() > 0 &&
					(!pending_requests[0].wait_idle || expected_responses.size() == 0)) begin
					in_flight = pending_requests.pop_front();
					req_valid  <= 1'b1;
					operation  <= in_flight.op;
					key        <= in_flight.key;
					item_value <= in_flight.value;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response side back-pressure: a rotating 16-bit ready pattern,
	// re-chosen whenever a random mode timer runs out (always ready, random, sparse).
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready     <= 1'b0;
			stall_pattern = 16'hFFFF;
			mode_timer    = 0;
		end else begin
			if (mode_timer == 0) begin
				mode_timer = $urandom_range(100, 400);
				case (stall_mode_t'($urandom_range(0, 2)))
					READY_ALWAYS: stall_pattern = 16'hFFFF;
					READY_RANDOM: stall_pattern = 16'($urandom);
					default: stall_pattern = (16'd1 << $urandom_range(0, 15))
						| (16'd1 << $urandom_range(0, 15));
				endcase
				if (stall_pattern == '0)
					stall_pattern = 16'd1;
			end else begin
				mode_timer--;
			end
			stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
			rsp_ready <= stall_pattern[0];
		end
	end

	// Response checker: every accepted word against the oldest prediction.
	always @(posedge clk) begin : check_response
		response_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			n_rsp++;
			if (expected_responses.size() == 0) begin
				$error("response word with no request outstanding");
				errors++;
			end else begin
				want = expected_responses.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
				if (position !== want.position) begin
					$error("position: expected %0d, got %0d", want.position, position);
					errors++;
				end
				if (found_value !== want.found_value) begin
					$error("found_value: expected %0h, got %0h", want.found_value, found_value);
					errors++;
				end
				if (fill_count !== want.fill_count) begin
					$error("fill_count: expected %0d, got %0d", want.fill_count, fill_count);
					errors++;
				end
			end
		end
	end

	// Watchdog: cycles since the last handshake on either channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		mix_t mix;
		int   seg_len;
		bit   first_seg;

		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = KEY_FW'($urandom_range(0, 65535));

		// Directed: empty-table misses, extreme keys and values, duplicates,
		// first-match on a duplicate, delete with shift, drain back to empty.
		queue_request(OP_LOOKUP, 16'h0000, 32'h0000_0000, 1'b0);
		queue_request(OP_DELETE, 16'h0005, 32'hFFFF_FFFF, 1'b0);
		queue_request(OP_INSERT, 16'h0000, 32'h0000_0000, 1'b0);
		queue_request(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
		queue_request(OP_INSERT, 16'h1234, 32'hA5A5_A5A5, 1'b0);
		queue_request(OP_INSERT, 16'hFFFF, 32'h5A5A_5A5A, 1'b0);
		queue_request(OP_LOOKUP, 16'hFFFF, 32'h0000_0000, 1'b0);
		queue_request(OP_LOOKUP, 16'h0000, 32'hFFFF_FFFF, 1'b0);
		queue_request(OP_LOOKUP, 16'h1234, 32'h0000_0000, 1'b0);
		queue_request(OP_LOOKUP, 16'h0007, 32'h0000_0000, 1'b0);
		queue_request(OP_DELETE, 16'hFFFF, 32'h0000_0000, 1'b0);
		queue_request(OP_LOOKUP, 16'hFFFF, 32'h0000_0000, 1'b0);
		queue_request(OP_DELETE, 16'h0000, 32'h0000_0000, 1'b0);
		queue_request(OP_DELETE, 16'h0000, 32'h0000_0000, 1'b0);
		queue_request(OP_DELETE, 16'hFFFF, 32'h0000_0000, 1'b0);
		queue_request(OP_DELETE, 16'h1234, 32'h0000_0000, 1'b0);
		queue_request(OP_LOOKUP, 16'h1234, 32'hFFFF_FFFF, 1'b0);

		// Random segments; the first one fills past capacity so full-table
		// drops and slot 63 show up early. Each segment starts on an idle table.
		first_seg = 1'b1;
		while (random_items < RANDOM_ITEMS) begin
			mix     = first_seg ? MIX_FILL : mix_t'($urandom_range(0, 2));
			seg_len = first_seg ? 120 : $urandom_range(30, 150);
			for (int i = 0; i < seg_len; i++)
				queue_request(pick_op(mix), pick_key(), pick_value(), i == 0);
			random_items += seg_len;
			first_seg = 1'b0;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (!(pending_requests.size() == 0 && !req_valid && expected_responses.size() == 0)
			&& quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);

		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$error("no handshake for %0d cycles, %0d responses outstanding",
				WATCHDOG_LIMIT, expected_responses.size());
			errors++;
		end else begin
			repeat (TAIL_CYCLES) @(posedge clk);
		end

		$display("%0d words sent (%0d lookup, %0d insert, %0d delete), %0d responses checked",
			n_lookup + n_insert + n_delete, n_lookup, n_insert, n_delete, n_rsp);
		$display("search hits %0d, misses %0d, full-table drops %0d, peak fill %0d",
			n_hit, n_miss, n_full, peak_fill);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
